// ===== hw/rtl/m1bu_pkg.sv =====
// ----------------------------------------------------------------------------
// m1bu_pkg
// Shared types and constants for the MIDI 1.0 byte to UMP word converter.
// ----------------------------------------------------------------------------
`default_nettype none

package m1bu_pkg;

  localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
  localparam logic [7:0] BYTE_MTC_QF      = 8'hF1;
  localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
  localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
  localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
  localparam logic [3:0] KIND_PROG_CHG    = 4'hC;
  localparam logic [3:0] KIND_CHAN_PRESS  = 4'hD;

  localparam logic [3:0] UMP_TYPE_SYSTEM  = 4'h1;
  localparam logic [3:0] UMP_TYPE_VOICE1  = 4'h2;
  localparam logic [3:0] UMP_TYPE_SYSEX7  = 4'h3;
  localparam logic [3:0] UMP_GROUP        = 4'h0;

  localparam logic [3:0] SX_COMPLETE      = 4'h0;
  localparam logic [3:0] SX_START         = 4'h1;
  localparam logic [3:0] SX_CONTINUE      = 4'h2;
  localparam logic [3:0] SX_END           = 4'h3;

  localparam int SX_CAP      = 6;
  localparam int SX_FILL_W   = 3;
  localparam int JOB_Q_DEPTH = 2;
  localparam int JOB_Q_AW    = $clog2(JOB_Q_DEPTH);
  localparam int JOB_Q_CW    = $clog2(JOB_Q_DEPTH + 1);

  typedef logic [SX_CAP-1:0][6:0] sx_bytes_t;

  // words owed for one input byte: optional sysex packet, then optional single word
  typedef struct packed {
    logic                 sx_en;
    logic [3:0]           sx_code;
    logic [SX_FILL_W-1:0] sx_fill;
    sx_bytes_t            sx_bytes;
    logic                 one_en;
    logic [31:0]          one_word;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/midi1_bytes_to_ump_words.sv =====
// ----------------------------------------------------------------------------
// midi1_bytes_to_ump_words
// MIDI 1.0 byte stream to 32-bit Universal MIDI Packet words, group 0.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                 | tuser / tlast
//  in_     | in  | [7:0] midi_byte       | tuser[0] restart
//  out_    | out | [31:0] ump_word       | tlast last_of_run
//
//  A byte is parsed in its accept cycle; words leave one per beat from a
//  registered output, so a byte yields 1 to 3 words (0 if absorbed).
//  Sustained rate is set by the output serializer: one word per cycle while out_tready is high.
//  A two-job queue lets the parser keep taking bytes while words drain.
//  Synchronous active-low reset clears parser, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module midi1_bytes_to_ump_words (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] midi_byte
  input  wire logic [0:0]  in_tuser,   // [0] restart
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] ump_word
  output logic             out_tlast
);

  m1bu_pkg::job_t push_job;
  m1bu_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           head_valid;
  logic           q_full;
  logic           accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  m1bu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .midi_byte_i (in_tdata),
    .restart_i   (in_tuser[0]),
    .job_o       (push_job),
    .job_push_o  (push)
  );

  m1bu_job_q u_job_q (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .head_o       (head_job),
    .head_valid_o (head_valid),
    .full_o       (q_full)
  );

  m1bu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_i       (head_job),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/m1bu_front.sv =====
// ----------------------------------------------------------------------------
// m1bu_front
// Byte parser: running status, data collection and sysex packing; hands the
// words owed for each byte to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module m1bu_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           accept_i,
  input  wire logic [7:0]     midi_byte_i,
  input  wire logic           restart_i,
  output m1bu_pkg::job_t      job_o,
  output logic                job_push_o
);

  logic [7:0]                     rs_r, rs_nxt;
  logic [1:0]                     need_r, need_nxt;
  logic [1:0]                     held_r, held_nxt;
  logic [6:0]                     hd0_r, hd0_nxt;
  logic [6:0]                     hd1_r, hd1_nxt;
  logic                           ix_r, ix_nxt;
  logic                           beg_r, beg_nxt;
  logic [m1bu_pkg::SX_FILL_W-1:0] fill_r, fill_nxt;
  m1bu_pkg::sx_bytes_t            buf_r, buf_nxt;
  m1bu_pkg::job_t                 job;

  always_comb begin
    logic [7:0] b;
    logic [1:0] held_inc;
    logic [3:0] wtype;
    b        = midi_byte_i;
    rs_nxt   = restart_i ? '0 : rs_r;
    need_nxt = restart_i ? '0 : need_r;
    held_nxt = restart_i ? '0 : held_r;
    hd0_nxt  = restart_i ? '0 : hd0_r;
    hd1_nxt  = restart_i ? '0 : hd1_r;
    ix_nxt   = restart_i ? 1'b0 : ix_r;
    beg_nxt  = restart_i ? 1'b0 : beg_r;
    fill_nxt = restart_i ? '0 : fill_r;
    buf_nxt  = restart_i ? '0 : buf_r;
    job      = '0;
    held_inc = '0;
    wtype    = '0;

    priority if (b >= m1bu_pkg::BYTE_REALTIME) begin
      job.one_en   = 1'b1;
      job.one_word = {m1bu_pkg::UMP_TYPE_SYSTEM, m1bu_pkg::UMP_GROUP, b, 16'h0000};
    end else if (b == m1bu_pkg::BYTE_SYSEX_START || b == m1bu_pkg::BYTE_SYSEX_END) begin
      if (ix_nxt) begin
        job.sx_en    = 1'b1;
        job.sx_code  = beg_nxt ? m1bu_pkg::SX_END : m1bu_pkg::SX_COMPLETE;
        job.sx_fill  = fill_nxt;
        job.sx_bytes = buf_nxt;
      end
      ix_nxt   = (b == m1bu_pkg::BYTE_SYSEX_START);
      beg_nxt  = ix_nxt ? 1'b0 : (beg_nxt | job.sx_en);
      fill_nxt = '0;
      buf_nxt  = '0;
      if (b == m1bu_pkg::BYTE_SYSEX_START) begin
        rs_nxt   = '0;
        held_nxt = '0;
      end
    end else if (ix_nxt && !b[7]) begin
      buf_nxt[fill_nxt] = b[6:0];
      if (fill_nxt == m1bu_pkg::SX_FILL_W'(m1bu_pkg::SX_CAP - 1)) begin
        job.sx_en    = 1'b1;
        job.sx_code  = beg_nxt ? m1bu_pkg::SX_CONTINUE : m1bu_pkg::SX_START;
        job.sx_fill  = m1bu_pkg::SX_FILL_W'(m1bu_pkg::SX_CAP);
        job.sx_bytes = buf_nxt;
        beg_nxt      = 1'b1;
        fill_nxt     = '0;
        buf_nxt      = '0;
      end else begin
        fill_nxt = fill_nxt + 1'b1;
      end
    end else begin
      if (ix_nxt) begin
        // status byte closes the open sysex
        job.sx_en    = 1'b1;
        job.sx_code  = beg_nxt ? m1bu_pkg::SX_END : m1bu_pkg::SX_COMPLETE;
        job.sx_fill  = fill_nxt;
        job.sx_bytes = buf_nxt;
        ix_nxt       = 1'b0;
        beg_nxt      = 1'b1;
        fill_nxt     = '0;
        buf_nxt      = '0;
      end
      if (b[7]) begin
        held_nxt = '0;
        if (b < m1bu_pkg::BYTE_SYSEX_START) begin
          rs_nxt   = b;
          need_nxt = (b[7:4] == m1bu_pkg::KIND_PROG_CHG ||
                      b[7:4] == m1bu_pkg::KIND_CHAN_PRESS) ? 2'd1 : 2'd2;
        end else if (b == m1bu_pkg::BYTE_MTC_QF || b == m1bu_pkg::BYTE_SONG_SEL) begin
          rs_nxt   = b;
          need_nxt = 2'd1;
        end else if (b == m1bu_pkg::BYTE_SONG_POS) begin
          rs_nxt   = b;
          need_nxt = 2'd2;
        end else begin
          rs_nxt       = '0;
          job.one_en   = 1'b1;
          job.one_word = {m1bu_pkg::UMP_TYPE_SYSTEM, m1bu_pkg::UMP_GROUP, b, 16'h0000};
        end
      end else if (rs_nxt != '0) begin
        if (held_nxt[0]) begin
          hd1_nxt = b[6:0];
        end else begin
          hd0_nxt = b[6:0];
        end
        held_inc = held_nxt + 2'd1;
        held_nxt = held_inc;
        if (held_inc >= need_nxt) begin
          wtype = (rs_nxt >= m1bu_pkg::BYTE_SYSEX_START) ?
                  m1bu_pkg::UMP_TYPE_SYSTEM : m1bu_pkg::UMP_TYPE_VOICE1;
          job.one_en   = 1'b1;
          job.one_word = {wtype, m1bu_pkg::UMP_GROUP, rs_nxt, 1'b0, hd0_nxt,
                          (need_nxt == 2'd2) ? {1'b0, hd1_nxt} : 8'h00};
          held_nxt = '0;
          if (rs_nxt >= m1bu_pkg::BYTE_SYSEX_START) begin
            rs_nxt = '0;
          end
        end
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && (job.sx_en || job.one_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r   <= '0;
      need_r <= '0;
      held_r <= '0;
      hd0_r  <= '0;
      hd1_r  <= '0;
      ix_r   <= 1'b0;
      beg_r  <= 1'b0;
      fill_r <= '0;
      buf_r  <= '0;
    end else if (accept_i) begin
      rs_r   <= rs_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
      hd0_r  <= hd0_nxt;
      hd1_r  <= hd1_nxt;
      ix_r   <= ix_nxt;
      beg_r  <= beg_nxt;
      fill_r <= fill_nxt;
      buf_r  <= buf_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/m1bu_job_q.sv =====
// ----------------------------------------------------------------------------
// m1bu_job_q
// Small job queue between parser and word serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module m1bu_job_q (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_i,
  input  wire m1bu_pkg::job_t push_job_i,
  input  wire logic           pop_i,
  output m1bu_pkg::job_t      head_o,
  output logic                head_valid_o,
  output logic                full_o
);

  m1bu_pkg::job_t                  mem_r [m1bu_pkg::JOB_Q_DEPTH];
  logic [m1bu_pkg::JOB_Q_AW-1:0]   wr_r, wr_nxt;
  logic [m1bu_pkg::JOB_Q_AW-1:0]   rd_r, rd_nxt;
  logic [m1bu_pkg::JOB_Q_CW-1:0]   cnt_r, cnt_nxt;

  assign head_o       = mem_r[rd_r];
  assign head_valid_o = (cnt_r != '0);
  assign full_o       = (cnt_r == m1bu_pkg::JOB_Q_CW'(m1bu_pkg::JOB_Q_DEPTH));

  always_comb begin
    wr_nxt  = push_i ? ((wr_r == m1bu_pkg::JOB_Q_AW'(m1bu_pkg::JOB_Q_DEPTH - 1)) ?
                        '0 : wr_r + 1'b1) : wr_r;
    rd_nxt  = pop_i  ? ((rd_r == m1bu_pkg::JOB_Q_AW'(m1bu_pkg::JOB_Q_DEPTH - 1)) ?
                        '0 : rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r + m1bu_pkg::JOB_Q_CW'(push_i) - m1bu_pkg::JOB_Q_CW'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= push_job_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/m1bu_back.sv =====
// ----------------------------------------------------------------------------
// m1bu_back
// Word serializer: formats sysex packets and sends one word per beat from the
// queued job, marking the final word of each job.
// ----------------------------------------------------------------------------
`default_nettype none

module m1bu_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire m1bu_pkg::job_t head_i,
  input  wire logic           head_valid_i,
  output logic                pop_o,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tlast
);

  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [31:0] data_r, data_nxt;
  logic        last_r, last_nxt;

  always_comb begin
    logic [31:0] w0;
    logic [31:0] w1;
    logic [1:0]  total;
    logic        adv;
    w0 = {m1bu_pkg::UMP_TYPE_SYSEX7, m1bu_pkg::UMP_GROUP, head_i.sx_code,
          1'b0, head_i.sx_fill, 1'b0, head_i.sx_bytes[0], 1'b0, head_i.sx_bytes[1]};
    w1 = {1'b0, head_i.sx_bytes[2], 1'b0, head_i.sx_bytes[3],
          1'b0, head_i.sx_bytes[4], 1'b0, head_i.sx_bytes[5]};
    total = (head_i.sx_en ? 2'd2 : 2'd0) + {1'b0, head_i.one_en};
    adv   = head_valid_i && (!vld_r || out_tready);

    idx_nxt  = idx_r;
    vld_nxt  = vld_r && !out_tready;
    data_nxt = data_r;
    last_nxt = last_r;
    pop_o    = 1'b0;

    if (adv) begin
      vld_nxt  = 1'b1;
      last_nxt = (idx_r == total - 2'd1);
      if (head_i.sx_en && idx_r == 2'd0) begin
        data_nxt = w0;
      end else if (head_i.sx_en && idx_r == 2'd1) begin
        data_nxt = w1;
      end else begin
        data_nxt = head_i.one_word;
      end
      if (last_nxt) begin
        pop_o   = 1'b1;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ===== dv/ump_word_checker.sv =====
// ----------------------------------------------------------------------------
// ump_word_checker
// Watches the byte and word streams of midi1_bytes_to_ump_words, predicts the
// UMP words owed for every accepted MIDI byte and compares them beat by beat.
// ----------------------------------------------------------------------------
module ump_word_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  input  logic [0:0]  in_tuser,   // [0] restart
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] ump_word
  input  logic        out_tlast,
  output int          mismatches,
  output int          words_owed,
  output int          words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } ump_beat_t;

  ump_beat_t owed_words[$];
  ump_beat_t want;

  // parser mirror
  logic [7:0] run_status = '0;
  logic [1:0] data_need  = '0;
  logic [1:0] data_held  = '0;
  logic [6:0] held [2]   = '{default: '0};
  logic       sx_open    = 1'b0;
  logic       sx_begun   = 1'b0;
  logic [2:0] sx_fill    = '0;
  logic [6:0] sx_buf [m1bu_pkg::SX_CAP] = '{default: '0};

  initial begin
    mismatches    = 0;
    words_owed    = 0;
    words_checked = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // two-word sysex packet from the buffer; empties the buffer
  function automatic logic [63:0] sysex_packet(input logic final_pkt);
    logic [3:0]  code;
    logic [31:0] w0;
    logic [31:0] w1;
    if (sx_begun) code = final_pkt ? m1bu_pkg::SX_END : m1bu_pkg::SX_CONTINUE;
    else          code = final_pkt ? m1bu_pkg::SX_COMPLETE : m1bu_pkg::SX_START;
    w0 = {m1bu_pkg::UMP_TYPE_SYSEX7, m1bu_pkg::UMP_GROUP, code, 1'b0, sx_fill,
          1'b0, sx_buf[0], 1'b0, sx_buf[1]};
    w1 = {1'b0, sx_buf[2], 1'b0, sx_buf[3], 1'b0, sx_buf[4], 1'b0, sx_buf[5]};
    sx_begun = 1'b1;
    sx_fill  = '0;
    for (int i = 0; i < m1bu_pkg::SX_CAP; i++) sx_buf[i] = '0;
    return {w0, w1};
  endfunction

  function automatic void predict_ump_words(input logic [7:0] b, input logic restart);
    logic [31:0] words [3];
    logic [63:0] pkt;
    logic [1:0]  sys_need;
    int          n;
    n = 0;
    if (restart) begin
      run_status = '0;
      data_need  = '0;
      data_held  = '0;
      held       = '{default: '0};
      sx_open    = 1'b0;
      sx_begun   = 1'b0;
      sx_fill    = '0;
      for (int i = 0; i < m1bu_pkg::SX_CAP; i++) sx_buf[i] = '0;
    end
    if (b >= m1bu_pkg::BYTE_REALTIME) begin
      words[n] = {m1bu_pkg::UMP_TYPE_SYSTEM, m1bu_pkg::UMP_GROUP, b, 16'h0000};
      n++;
    end else if (b == m1bu_pkg::BYTE_SYSEX_START) begin
      if (sx_open) begin
        pkt = sysex_packet(1'b1);
        words[0] = pkt[63:32];
        words[1] = pkt[31:0];
        n = 2;
      end
      sx_open    = 1'b1;
      sx_begun   = 1'b0;
      sx_fill    = '0;
      for (int i = 0; i < m1bu_pkg::SX_CAP; i++) sx_buf[i] = '0;
      run_status = '0;
      data_held  = '0;
    end else if (b == m1bu_pkg::BYTE_SYSEX_END) begin
      if (sx_open) begin
        pkt = sysex_packet(1'b1);
        words[0] = pkt[63:32];
        words[1] = pkt[31:0];
        n = 2;
        sx_open = 1'b0;
      end
    end else if (sx_open && !b[7]) begin
      sx_buf[sx_fill] = b[6:0];
      sx_fill++;
      if (sx_fill == m1bu_pkg::SX_FILL_W'(m1bu_pkg::SX_CAP)) begin
        pkt = sysex_packet(1'b0);
        words[0] = pkt[63:32];
        words[1] = pkt[31:0];
        n = 2;
      end
    end else begin
      if (sx_open) begin
        pkt = sysex_packet(1'b1);
        words[0] = pkt[63:32];
        words[1] = pkt[31:0];
        n = 2;
        sx_open = 1'b0;
      end
      if (b[7]) begin
        data_held = '0;
        if (b < m1bu_pkg::BYTE_SYSEX_START) begin
          run_status = b;
          data_need  = (b[7:4] == m1bu_pkg::KIND_PROG_CHG ||
                        b[7:4] == m1bu_pkg::KIND_CHAN_PRESS) ? 2'd1 : 2'd2;
        end else begin
          run_status = '0;
          case (b)
            m1bu_pkg::BYTE_MTC_QF, m1bu_pkg::BYTE_SONG_SEL: sys_need = 2'd1;
            m1bu_pkg::BYTE_SONG_POS:                        sys_need = 2'd2;
            default:                                        sys_need = 2'd0;
          endcase
          if (sys_need == 2'd0) begin
            words[n] = {m1bu_pkg::UMP_TYPE_SYSTEM, m1bu_pkg::UMP_GROUP, b, 16'h0000};
            n++;
          end else begin
            run_status = b;
            data_need  = sys_need;
          end
        end
      end else if (run_status != 8'h00) begin
        held[data_held[0]] = b[6:0];
        data_held++;
        if (data_held >= data_need) begin
          words[n] = {(run_status >= m1bu_pkg::BYTE_SYSEX_START) ?
                        m1bu_pkg::UMP_TYPE_SYSTEM : m1bu_pkg::UMP_TYPE_VOICE1,
                      m1bu_pkg::UMP_GROUP, run_status, 1'b0, held[0],
                      (data_need == 2'd2) ? {1'b0, held[1]} : 8'h00};
          n++;
          data_held = '0;
          if (run_status >= m1bu_pkg::BYTE_SYSEX_START) run_status = '0;
        end
      end
    end
    for (int i = 0; i < n; i++)
      owed_words.insert(owed_words.size(), ump_beat_t'{word: words[i], last: (i == n - 1)});
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_ump_words(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) begin
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("word %08h with none owed", out_tdata));
        end else begin
          want = owed_words.pop_front();
          words_checked++;
          if (out_tdata !== want.word)
            report_mismatch($sformatf("ump_word %08h, want %08h", out_tdata, want.word));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b on word %08h",
                                      out_tlast, want.last, want.word));
        end
      end
    end
    words_owed <= owed_words.size();
  end

endmodule

// ===== dv/tb_midi1_bytes_to_ump_words.sv =====
// ----------------------------------------------------------------------------
// tb_midi1_bytes_to_ump_words
// Drives MIDI 1.0 byte streams (voice, system common, real-time, sysex,
// restarts and noise) into the converter under several idle/stall mixes,
// including a long output hold; ump_word_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_midi1_bytes_to_ump_words;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT   = 300000;
  localparam int PHASE_BYTES = 40;
  localparam int HOLD_CYCLES = 400;

  localparam logic [8:0] DIRECTED [27] = '{
    9'h0FF, 9'h005, {1'b0, m1bu_pkg::BYTE_SYSEX_END},
    9'h090, 9'h000, 9'h07F, 9'h0C3, 9'h040,
    9'h0F2, 9'h07F, 9'h07F, 9'h0F6,
    {1'b0, m1bu_pkg::BYTE_SYSEX_START}, {1'b0, m1bu_pkg::BYTE_SYSEX_END},
    {1'b0, m1bu_pkg::BYTE_SYSEX_START}, 9'h001, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006,
    9'h0F9, {1'b0, m1bu_pkg::BYTE_SYSEX_END},
    {1'b0, m1bu_pkg::BYTE_SYSEX_START}, 9'h02A, {1'b0, m1bu_pkg::BYTE_SYSEX_START},
    9'h0E0
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  int mismatches;
  int words_owed;
  int words_checked;
  int bytes_sent      = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_reqs       = 0;
  int holds_done      = 0;
  int cycles          = 0;

  midi1_bytes_to_ump_words u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ump_word_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatches    (mismatches),
    .words_owed    (words_owed),
    .words_checked (words_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // output side: random stalls, plus a long hold whenever one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && hold_reqs != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still owed", cycles, words_owed);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(99) < 8)
      send_beat(8'($urandom_range(m1bu_pkg::BYTE_REALTIME, 8'hFF)), 1'b0);
    send_beat(b, 1'b0);
  endtask

  task automatic drain_words();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_message();
    int          pick;
    int          reps;
    int          len;
    int          need;
    logic [7:0]  status;
    pick = $urandom_range(99);
    if (pick < 30) begin
      status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
      need   = (status[7:4] == m1bu_pkg::KIND_PROG_CHG ||
                status[7:4] == m1bu_pkg::KIND_CHAN_PRESS) ? 1 : 2;
      reps   = $urandom_range(1, 3);
      send_beat(status, 1'b0);
      for (int r = 0; r < reps * need; r++) send_data(8'($urandom_range(0, 127)));
    end else if (pick < 40) begin
      status = 8'($urandom_range(m1bu_pkg::BYTE_MTC_QF, 8'hF6));
      send_beat(status, 1'b0);
      need = (status == m1bu_pkg::BYTE_SONG_POS) ? 2 :
             (status == m1bu_pkg::BYTE_MTC_QF || status == m1bu_pkg::BYTE_SONG_SEL) ? 1 : 0;
      for (int r = 0; r < need; r++) send_data(8'($urandom_range(0, 127)));
    end else if (pick < 70) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(0, 13) : $urandom_range(14, 25);
      send_beat(m1bu_pkg::BYTE_SYSEX_START, 1'b0);
      for (int r = 0; r < len; r++) send_data(8'($urandom_range(0, 127)));
      pick = $urandom_range(99);
      if (pick < 70)      send_beat(m1bu_pkg::BYTE_SYSEX_END, 1'b0);
      else if (pick < 85) send_beat(8'($urandom_range(8'h80, 8'hF6)), 1'b0);
      else if (pick < 93) send_beat(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 80) begin
      send_beat(8'($urandom_range(m1bu_pkg::BYTE_REALTIME, 8'hFF)), 1'b0);
    end else if (pick < 90) begin
      send_beat(8'($urandom_range(0, 255)), ($urandom_range(99) < 15));
    end else begin
      // truncated voice message, then a stray or restarted byte
      send_beat({4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))}, 1'b0);
      if ($urandom_range(1)) send_data(8'($urandom_range(0, 127)));
      send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_beat(DIRECTED[i][7:0], DIRECTED[i][8]);
    send_beat(8'h12, 1'b1);
    drain_words();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 53; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 53; end
        default: begin sender_idle_pct = 13; stall_pct = 13; end
      endcase
      if (phase == 0) begin
        hold_reqs++;
        for (int m = 0; m < 12; m++) send_message();
      end
      begin
        int stop_at;
        stop_at = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at) send_message();
      end
      drain_words();
    end

    drain_words();
    repeat (16) @(posedge clk);
    $display("Sent %0d MIDI bytes (voice, system, real-time, sysex, restarts, noise)",
             bytes_sent);
    $display("over four idle/stall mixes and a long output hold; %0d UMP words checked",
             words_checked);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/m1bu_pkg.sv
hw/rtl/m1bu_front.sv
hw/rtl/m1bu_job_q.sv
hw/rtl/m1bu_back.sv
hw/rtl/midi1_bytes_to_ump_words.sv
dv/ump_word_checker.sv
dv/tb_midi1_bytes_to_ump_words.sv
